// ----- src/mzx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzx_pkg - shared types and constants for the maze explorer
// Direction, status and fault codes, defaults, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mzx_pkg;

  localparam int GRID_DIM_DEF    = 64;
  localparam int STACK_DEPTH_DEF = 16384;
  localparam int STEP_BITS_DEF   = 16;

  localparam int POS_OUT_W   = 6;
  localparam int STEP_OUT_W  = 16;
  localparam int DIR_OUT_W   = 3;
  localparam int FAULT_W     = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_DATA_W-1:0] START_RST = 6'd32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

  // internal direction codes (output code is one higher)
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_W = 2'd2;
  localparam logic [1:0] DIR_E = 2'd3;

  localparam logic OP_NEXT_MOVE = 1'b0;
  localparam logic OP_STATUS    = 1'b1;

  localparam logic [1:0] ST_WALL   = 2'd0;
  localparam logic [1:0] ST_OXYGEN = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVF  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_EXIT = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_MARK,
    S_DECODE,
    S_POP,
    S_LOOKUP,
    S_UPDATE,
    S_PUSH,
    S_DONE
  } mzx_state_t;

  typedef struct packed {
    logic       clr_step;
    logic       latch_in;
    logic       init_start;
    logic       mark_start;
    logic       pop_rd;
    logic       pop_load;
    logic       tgt_calc;
    logic       wall_wr;
    logic       cell_rd;
    logic       update;
    logic       push;
    logic [1:0] push_idx;
    logic       out_load;
  } mzx_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic started;
    logic opcode;
    logic is_wall;
    logic stack_empty;
    logic tgt_exit;
    logic cell_known;
    logic out_free;
  } mzx_sts_t;

endpackage
`default_nettype wire

// ----- src/mzx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzx_ctrl - sequencer for the maze explorer
// Walks each request through decode and then a stack pop or map lookup,
// update and stack pushes, and runs the map clearing pass after reset.
// ----------------------------------------------------------------------------
module mzx_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mzx_pkg::mzx_sts_t sts,
  output mzx_pkg::mzx_cmd_t     cmd
);

  mzx_pkg::mzx_state_t state_r, state_nxt;
  logic [1:0]          push_cnt_r, push_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mzx_pkg::S_CLEAR;
      push_cnt_r <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      push_cnt_r <= push_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    push_cnt_nxt = push_cnt_r;
    case (state_r)
      mzx_pkg::S_CLEAR: begin
        if (sts.clr_last) state_nxt = mzx_pkg::S_IDLE;
      end
      mzx_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sts.started ? mzx_pkg::S_DECODE : mzx_pkg::S_INIT;
      end
      mzx_pkg::S_INIT:  state_nxt = mzx_pkg::S_MARK;
      mzx_pkg::S_MARK:  state_nxt = mzx_pkg::S_DECODE;
      mzx_pkg::S_DECODE: begin
        if (sts.opcode == mzx_pkg::OP_NEXT_MOVE) begin
          state_nxt = sts.stack_empty ? mzx_pkg::S_DONE : mzx_pkg::S_POP;
        end else begin
          state_nxt = mzx_pkg::S_LOOKUP;
        end
      end
      mzx_pkg::S_POP:   state_nxt = mzx_pkg::S_DONE;
      mzx_pkg::S_LOOKUP: begin
        if (sts.tgt_exit || sts.is_wall) state_nxt = mzx_pkg::S_DONE;
        else state_nxt = mzx_pkg::S_UPDATE;
      end
      mzx_pkg::S_UPDATE: begin
        push_cnt_nxt = 2'd0;
        state_nxt    = sts.cell_known ? mzx_pkg::S_DONE : mzx_pkg::S_PUSH;
      end
      mzx_pkg::S_PUSH: begin
        push_cnt_nxt = push_cnt_r + 2'd1;
        if (push_cnt_r == 2'd3) state_nxt = mzx_pkg::S_DONE;
      end
      mzx_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = mzx_pkg::S_IDLE;
      end
      default: state_nxt = mzx_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mzx_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      mzx_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      mzx_pkg::S_INIT:  cmd.init_start = 1'b1;
      mzx_pkg::S_MARK:  cmd.mark_start = 1'b1;
      mzx_pkg::S_DECODE: begin
        if (sts.opcode == mzx_pkg::OP_NEXT_MOVE) cmd.pop_rd = 1'b1;
        else cmd.tgt_calc = 1'b1;
      end
      mzx_pkg::S_POP:   cmd.pop_load = 1'b1;
      mzx_pkg::S_LOOKUP: begin
        if (!sts.tgt_exit) begin
          if (sts.is_wall) cmd.wall_wr = 1'b1;
          else cmd.cell_rd = 1'b1;
        end
      end
      mzx_pkg::S_UPDATE: cmd.update = 1'b1;
      mzx_pkg::S_PUSH: begin
        cmd.push     = 1'b1;
        cmd.push_idx = push_cnt_r;
      end
      mzx_pkg::S_DONE:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/mzx_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzx_dp - datapath of the maze explorer
// Cell map and move stack memories, robot position, step counters,
// start registers and the result register.
// ----------------------------------------------------------------------------
module mzx_dp #(
  parameter int GRID_DIM    = mzx_pkg::GRID_DIM_DEF,
  parameter int STACK_DEPTH = mzx_pkg::STACK_DEPTH_DEF,
  parameter int STEP_BITS   = mzx_pkg::STEP_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [mzx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mzx_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_opcode,
  input  wire logic [1:0]                        in_move_status,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mzx_pkg::DIR_OUT_W-1:0]          out_direction,
  output logic [mzx_pkg::POS_OUT_W-1:0]          out_pos_x,
  output logic [mzx_pkg::POS_OUT_W-1:0]          out_pos_y,
  output logic [mzx_pkg::STEP_OUT_W-1:0]         out_step_count,
  output logic                                   out_oxygen_found,
  output logic [mzx_pkg::STEP_OUT_W-1:0]         out_longest_steps,
  output logic [mzx_pkg::FAULT_W-1:0]            out_fault,
  input  wire mzx_pkg::mzx_cmd_t                 cmd,
  output mzx_pkg::mzx_sts_t                      sts
);

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int PW    = $clog2(GRID_DIM);
  localparam int AW    = $clog2(CELLS);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CNTW  = $clog2(STACK_DEPTH + 1);
  localparam int CW    = STEP_BITS + 2;
  localparam int MW    = ((PW > mzx_pkg::CFG_DATA_W) ? PW : mzx_pkg::CFG_DATA_W) + 1;
  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

  // start coordinate reduced modulo the grid size (exact for GRID_DIM of 8 or more)
  function automatic logic [PW-1:0] wrap_start(input logic [mzx_pkg::CFG_DATA_W-1:0] s);
    logic [MW-1:0] v;
    v = MW'(s);
    for (int i = 0; i < 8; i++) begin
      if (v >= MW'(GRID_DIM)) v = v - MW'(GRID_DIM);
    end
    return PW'(v);
  endfunction

  // N, E, S, W
  function automatic logic [1:0] order_dir(input logic [1:0] j);
    logic [1:0] d;
    case (j)
      2'd0:    d = mzx_pkg::DIR_N;
      2'd1:    d = mzx_pkg::DIR_E;
      2'd2:    d = mzx_pkg::DIR_S;
      default: d = mzx_pkg::DIR_W;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] order_pos(input logic [1:0] d);
    logic [1:0] p;
    case (d)
      mzx_pkg::DIR_N: p = 2'd0;
      mzx_pkg::DIR_E: p = 2'd1;
      mzx_pkg::DIR_S: p = 2'd2;
      default:        p = 2'd3;
    endcase
    return p;
  endfunction

  // reverse move first, then the other three in N, E, S, W order
  function automatic logic [1:0] push_dir(input logic [1:0] back, input logic [1:0] k);
    logic [1:0] j;
    logic [1:0] d;
    j = k - 2'd1;
    if (k == 2'd0) d = back;
    else if (j < order_pos(back)) d = order_dir(j);
    else d = order_dir(j + 2'd1);
    return d;
  endfunction

  logic [CW-1:0]        cell_mem [CELLS];
  logic [1:0]           stack_mem [STACK_DEPTH];

  logic [mzx_pkg::CFG_DATA_W-1:0] start_x_r, start_y_r;
  logic [PW-1:0]        robot_x_r, robot_y_r;
  logic [PW-1:0]        tgt_x_r, tgt_y_r;
  logic                 tgt_exit_r;
  logic [1:0]           heading_r;
  logic [STEP_BITS-1:0] steps_r, max_r;
  logic                 found_r, started_r;
  logic [CNTW-1:0]      stk_cnt_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [mzx_pkg::FAULT_W-1:0] fault_r;
  logic                 op_r;
  logic [1:0]           st_r;
  logic [CW-1:0]        cell_q;
  logic [1:0]           stk_q;
  logic                 out_valid_r;

  logic [PW-1:0]        nx, ny;
  logic                 nexit;
  logic [PW-1:0]        sel_x, sel_y;
  logic [AW-1:0]        cell_idx;
  logic                 cell_we;
  logic [AW-1:0]        cell_waddr;
  logic [CW-1:0]        cell_wdata;
  logic                 stk_we;
  logic [SAW-1:0]       stk_waddr;
  logic [1:0]           stk_wdata;
  logic [CNTW-1:0]      stk_cnt_dec;
  logic                 stk_empty, stk_full;
  logic                 known;
  logic [STEP_BITS-1:0] new_steps;

  assign stk_cnt_dec = stk_cnt_r - CNTW'(1);
  assign stk_empty   = (stk_cnt_r == '0);
  assign stk_full    = (stk_cnt_r == CNTW'(STACK_DEPTH));
  assign known       = cell_q[CW-1];
  assign new_steps   = (steps_r == STEP_MAX) ? steps_r : steps_r + STEP_BITS'(1);

  // target of the current heading
  always_comb begin
    nx    = robot_x_r;
    ny    = robot_y_r;
    nexit = 1'b0;
    case (heading_r)
      mzx_pkg::DIR_N: begin
        nexit = (robot_y_r == PW'(GRID_DIM - 1));
        ny    = robot_y_r + PW'(1);
      end
      mzx_pkg::DIR_S: begin
        nexit = (robot_y_r == '0);
        ny    = robot_y_r - PW'(1);
      end
      mzx_pkg::DIR_W: begin
        nexit = (robot_x_r == '0);
        nx    = robot_x_r - PW'(1);
      end
      default: begin
        nexit = (robot_x_r == PW'(GRID_DIM - 1));
        nx    = robot_x_r + PW'(1);
      end
    endcase
  end

  assign sel_x    = cmd.mark_start ? robot_x_r : tgt_x_r;
  assign sel_y    = cmd.mark_start ? robot_y_r : tgt_y_r;
  assign cell_idx = AW'(sel_y) * AW'(GRID_DIM) + AW'(sel_x);

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_idx;
    cell_wdata = '0;
    if (cmd.clr_step) begin
      cell_we    = 1'b1;
      cell_waddr = clr_cnt_r;
    end else if (cmd.mark_start) begin
      cell_we    = 1'b1;
      cell_wdata = {1'b1, 1'b0, {STEP_BITS{1'b0}}};
    end else if (cmd.wall_wr) begin
      cell_we    = 1'b1;
      cell_wdata = {1'b1, 1'b1, {STEP_BITS{1'b0}}};
    end else if (cmd.update && !known) begin
      cell_we    = 1'b1;
      cell_wdata = {1'b1, 1'b0, new_steps};
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = stk_cnt_r[SAW-1:0];
    stk_wdata = push_dir(heading_r ^ 2'd1, cmd.push_idx);
    if (cmd.clr_step) begin
      stk_we    = (clr_cnt_r < AW'(4));
      stk_waddr = SAW'(clr_cnt_r[1:0]);
      stk_wdata = order_dir(clr_cnt_r[1:0]);
    end else if (cmd.push) begin
      stk_we = !stk_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cmd.cell_rd) cell_q <= cell_mem[cell_idx];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (cmd.pop_rd) stk_q <= stack_mem[stk_cnt_dec[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= mzx_pkg::START_RST;
      start_y_r   <= mzx_pkg::START_RST;
      robot_x_r   <= '0;
      robot_y_r   <= '0;
      tgt_exit_r  <= 1'b0;
      heading_r   <= mzx_pkg::DIR_N;
      steps_r     <= '0;
      max_r       <= '0;
      found_r     <= 1'b0;
      started_r   <= 1'b0;
      stk_cnt_r   <= CNTW'(4);
      clr_cnt_r   <= '0;
      fault_r     <= mzx_pkg::FAULT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == mzx_pkg::CFG_START_X) start_x_r <= cfg_data;
      if (cfg_we && cfg_index == mzx_pkg::CFG_START_Y) start_y_r <= cfg_data;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.latch_in) fault_r <= mzx_pkg::FAULT_NONE;
      if (cmd.init_start) begin
        robot_x_r <= wrap_start(start_x_r);
        robot_y_r <= wrap_start(start_y_r);
        started_r <= 1'b1;
      end
      if (cmd.pop_rd) begin
        if (stk_empty) heading_r <= mzx_pkg::DIR_N;
        else stk_cnt_r <= stk_cnt_dec;
      end
      if (cmd.pop_load) heading_r <= stk_q;
      if (cmd.tgt_calc) begin
        tgt_exit_r <= nexit;
        if (nexit) fault_r <= mzx_pkg::FAULT_EXIT;
      end
      if (cmd.update) begin
        robot_x_r <= tgt_x_r;
        robot_y_r <= tgt_y_r;
        if (known) begin
          steps_r <= cell_q[STEP_BITS-1:0];
        end else begin
          steps_r <= new_steps;
          if (new_steps > max_r) max_r <= new_steps;
        end
        if (st_r == mzx_pkg::ST_OXYGEN) found_r <= 1'b1;
      end
      if (cmd.push) begin
        if (stk_full) fault_r <= mzx_pkg::FAULT_OVF;
        else stk_cnt_r <= stk_cnt_r + CNTW'(1);
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= in_opcode;
      st_r <= in_move_status;
    end
    if (cmd.tgt_calc) begin
      tgt_x_r <= nx;
      tgt_y_r <= ny;
    end
    if (cmd.out_load) begin
      out_direction     <= mzx_pkg::DIR_OUT_W'(heading_r) + mzx_pkg::DIR_OUT_W'(1);
      out_pos_x         <= mzx_pkg::POS_OUT_W'(robot_x_r);
      out_pos_y         <= mzx_pkg::POS_OUT_W'(robot_y_r);
      out_step_count    <= mzx_pkg::STEP_OUT_W'(steps_r);
      out_oxygen_found  <= found_r;
      out_longest_steps <= mzx_pkg::STEP_OUT_W'(max_r);
      out_fault         <= fault_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts             = '0;
    sts.clr_last    = (clr_cnt_r == AW'(CELLS - 1));
    sts.started     = started_r;
    sts.opcode      = op_r;
    sts.is_wall     = (st_r == mzx_pkg::ST_WALL);
    sts.stack_empty = stk_empty;
    sts.tgt_exit    = tgt_exit_r;
    sts.cell_known  = known;
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

// ----- src/maze_explorer_dfs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// maze_explorer_dfs - depth-first maze mapper for a grid robot
// Input requests (valid/ready) carry an opcode and the robot's move status;
// each request yields one result (valid/ready): direction, position, step
// count, oxygen flag, longest step count and a fault code.
// Start column and row are to be written by the user through
// cfg_we/cfg_index/cfg_data while idle, which the block does not enforce;
// they are taken at the first request after reset. After reset all
// GRID_DIM*GRID_DIM cells (4096 by default) of the cell map are cleared,
// one cell per cycle; in_ready stays low meanwhile. A next-move request
// runs decode and a stack pop (decode alone with an empty stack); a status
// report runs decode and map lookup, ending there for a wall or a grid
// exit, then an update onto a known cell, or an update and four stack
// pushes onto a new cell, one per cycle through the single stack write port.
// The first request after reset first places the robot and marks its cell.
// One request is worked on at a time. The result register holds a result
// until taken; a new request may be accepted meanwhile, and its result
// waits in the controller until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module maze_explorer_dfs #(
  parameter int GRID_DIM    = mzx_pkg::GRID_DIM_DEF,
  parameter int STACK_DEPTH = mzx_pkg::STACK_DEPTH_DEF,
  parameter int STEP_BITS   = mzx_pkg::STEP_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mzx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mzx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_opcode,
  input  wire logic [1:0]                     in_move_status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mzx_pkg::DIR_OUT_W-1:0]       out_direction,
  output logic [mzx_pkg::POS_OUT_W-1:0]       out_pos_x,
  output logic [mzx_pkg::POS_OUT_W-1:0]       out_pos_y,
  output logic [mzx_pkg::STEP_OUT_W-1:0]      out_step_count,
  output logic                                out_oxygen_found,
  output logic [mzx_pkg::STEP_OUT_W-1:0]      out_longest_steps,
  output logic [mzx_pkg::FAULT_W-1:0]         out_fault
);

  mzx_pkg::mzx_cmd_t cmd;
  mzx_pkg::mzx_sts_t sts;

  mzx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mzx_dp #(
    .GRID_DIM    (GRID_DIM),
    .STACK_DEPTH (STACK_DEPTH),
    .STEP_BITS   (STEP_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_move_status    (in_move_status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_direction     (out_direction),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_step_count    (out_step_count),
    .out_oxygen_found  (out_oxygen_found),
    .out_longest_steps (out_longest_steps),
    .out_fault         (out_fault),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
`default_nettype wire
